// ===== sv/vsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_pkg
// Shared types and codes for the vectored interrupt save and restore block.
// ----------------------------------------------------------------------------
package vsr_pkg;

  localparam int unsigned DATA_W    = 27;
  localparam int unsigned MASK_W    = 9;
  localparam int unsigned REG_SEL_W = 6;
  localparam int unsigned SP_PAD_W  = 32 - DATA_W;
  localparam int unsigned ADDR_STEP = 3;

  // Command codes.
  localparam logic [2:0] CMD_SET     = 3'd0;
  localparam logic [2:0] CMD_GET     = 3'd1;
  localparam logic [2:0] CMD_ENABLE  = 3'd2;
  localparam logic [2:0] CMD_DISABLE = 3'd3;
  localparam logic [2:0] CMD_FIRE    = 3'd4;
  localparam logic [2:0] CMD_RETURN  = 3'd5;

  // Memory access codes.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_WRITE = 2'd1;
  localparam logic [1:0] MEM_READ  = 2'd2;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [3:0]        irq_id;
    logic [DATA_W-1:0] vector_value;
    logic [MASK_W-1:0] id_mask;
    logic [DATA_W-1:0] stack_pointer;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]    read_vector;
    logic [1:0]           mem_op;
    logic [DATA_W-1:0]    mem_addr;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wake;
    logic                 branch_taken;
    logic [DATA_W-1:0]    new_pc;
    logic [DATA_W-1:0]    new_stack;
    logic                 clear_exception;
    logic                 last;
  } result_t;

endpackage

// ===== sv/vsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vsr_ram #(
  parameter int unsigned WIDTH = 27,
  parameter int unsigned DEPTH = 9,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/vsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_ctrl
// Command sequencer: vector table access, enable mask, and the save and
// restore word sequence towards the stack.
// ----------------------------------------------------------------------------
module vsr_ctrl #(
  parameter int unsigned NUM_VECTORS = 9,
  parameter int unsigned ADDR_BITS   = 27,
  parameter int unsigned NUM_REGS    = 32,
  parameter int unsigned VAW         = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  vsr_pkg::item_t            item,
  input  logic                      stack_direction,
  output logic                      busy,
  output logic                      result_valid,
  output vsr_pkg::result_t          result,
  output logic                      ram_we,
  output logic [VAW-1:0]            ram_waddr,
  output logic [vsr_pkg::DATA_W-1:0] ram_wdata,
  output logic [VAW-1:0]            ram_raddr,
  input  logic [vsr_pkg::DATA_W-1:0] ram_rdata
);

  localparam int unsigned CW = $clog2(NUM_REGS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEQ
  } state_t;

  state_t                          state;
  logic [2:0]                      cmd_q;
  logic [3:0]                      id_q;
  logic                            id_ok_q;
  logic                            rd_ok;
  logic [ADDR_BITS-1:0]            sp_q;
  logic [vsr_pkg::MASK_W-1:0]      enable_mask;
  logic [NUM_VECTORS-1:0]          vec_valid;
  logic [ADDR_BITS-1:0]            addr;
  logic [vsr_pkg::REG_SEL_W-1:0]   reg_idx;
  logic [CW-1:0]                   cnt;
  logic                            down_q;
  logic                            fire_q;
  logic [vsr_pkg::DATA_W-1:0]      pc_q;

  logic                            accept;
  logic                            id_ok;
  logic [VAW-1:0]                  id_idx;
  logic                            is_fire;
  logic                            taken;
  logic                            seq_go;
  logic                            down;
  logic [ADDR_BITS-1:0]            sp_in;
  logic [ADDR_BITS-1:0]            addr_next;
  logic [31:0]                     addr_wide;
  logic [31:0]                     next_wide;
  logic                            final_word;
  vsr_pkg::result_t                single;
  vsr_pkg::result_t                seq_word;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (item.irq_id < 4'(NUM_VECTORS));
  assign id_idx = VAW'(item.irq_id);
  assign sp_in  = ADDR_BITS'({{vsr_pkg::SP_PAD_W{1'b0}}, item.stack_pointer});

  // The table is written straight from the accepted word; reads see it later.
  assign ram_we    = accept && (item.cmd == vsr_pkg::CMD_SET) && id_ok;
  assign ram_waddr = id_idx;
  assign ram_wdata = item.vector_value;
  assign ram_raddr = id_idx;

  always_comb begin
    is_fire    = (cmd_q == vsr_pkg::CMD_FIRE);
    taken      = is_fire && id_ok_q && rd_ok && (ram_rdata != '0) && enable_mask[id_q];
    seq_go     = taken || (cmd_q == vsr_pkg::CMD_RETURN);
    down       = is_fire ? !stack_direction : stack_direction;
    addr_next  = down_q ? (addr - ADDR_BITS'(vsr_pkg::ADDR_STEP))
                        : (addr + ADDR_BITS'(vsr_pkg::ADDR_STEP));
    addr_wide  = 32'(addr);
    next_wide  = 32'(addr_next);
    final_word = (cnt == CW'(NUM_REGS));

    single      = '0;
    single.last = 1'b1;
    if (cmd_q == vsr_pkg::CMD_GET && rd_ok) begin
      single.read_vector = ram_rdata;
    end
    if (is_fire && id_ok_q) begin
      single.wake = 1'b1;
    end

    seq_word                 = '0;
    seq_word.mem_op          = fire_q ? vsr_pkg::MEM_WRITE : vsr_pkg::MEM_READ;
    seq_word.mem_addr        = addr_wide[vsr_pkg::DATA_W-1:0];
    seq_word.reg_sel         = reg_idx;
    seq_word.wake            = fire_q;
    seq_word.last            = final_word;
    seq_word.branch_taken    = final_word;
    seq_word.clear_exception = final_word && !fire_q;
    if (final_word && fire_q) begin
      seq_word.new_pc    = pc_q;
      // Saving downwards leaves the stack at the last word's address.
      seq_word.new_stack = down_q ? addr_wide[vsr_pkg::DATA_W-1:0]
                                  : next_wide[vsr_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      enable_mask  <= '0;
      vec_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          result_valid <= 1'b0;
          if (accept) begin
            cmd_q   <= item.cmd;
            id_q    <= item.irq_id;
            id_ok_q <= id_ok;
            rd_ok   <= id_ok && vec_valid[id_idx];
            sp_q    <= sp_in;
            if (ram_we) begin
              vec_valid[id_idx] <= 1'b1;
            end
            if (item.cmd == vsr_pkg::CMD_ENABLE) begin
              enable_mask <= item.id_mask;
            end else if (item.cmd == vsr_pkg::CMD_DISABLE) begin
              enable_mask <= ~item.id_mask;
            end
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (seq_go) begin
            addr         <= down ? (sp_q - ADDR_BITS'(vsr_pkg::ADDR_STEP)) : sp_q;
            reg_idx      <= down ? vsr_pkg::REG_SEL_W'(NUM_REGS) : '0;
            cnt          <= '0;
            down_q       <= down;
            fire_q       <= is_fire;
            pc_q         <= ram_rdata;
            result_valid <= 1'b0;
            state        <= ST_SEQ;
          end else begin
            result       <= single;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_SEQ: begin
          result       <= seq_word;
          result_valid <= 1'b1;
          addr         <= addr_next;
          reg_idx      <= down_q ? (reg_idx - vsr_pkg::REG_SEL_W'(1))
                                 : (reg_idx + vsr_pkg::REG_SEL_W'(1));
          cnt          <= cnt + CW'(1);
          if (final_word) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          result_valid <= 1'b0;
          state        <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/vectored_interrupt_save_restore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vectored_interrupt_save_restore
// Interrupt vector table with enable mask, sequencing register save and
// restore words to a memory stack.
// ----------------------------------------------------------------------------
// A taken fire or a return gives NUM_REGS+1 words, one per cycle, registered
// from the SEQ state, which follows the EXEC state; busy stays high through
// both states, so the next command is accepted only once the sequence ends.
// Every other command gives one word from the EXEC state, busy only there.
// Results are strobed for one cycle; the receiver cannot stall them.
// Synchronous reset clears the table valid bits, enable mask and direction.
module vectored_interrupt_save_restore #(
  parameter int unsigned NUM_VECTORS = 9,
  parameter int unsigned ADDR_BITS   = 27,
  parameter int unsigned NUM_REGS    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vsr_pkg::item_t   item,
  output logic             result_valid,
  output vsr_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  localparam int unsigned VAW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;

  logic                       stack_direction;
  logic                       ram_we;
  logic [VAW-1:0]             ram_waddr;
  logic [vsr_pkg::DATA_W-1:0] ram_wdata;
  logic [VAW-1:0]             ram_raddr;
  logic [vsr_pkg::DATA_W-1:0] ram_rdata;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      stack_direction <= cfg_data;
    end
  end

  vsr_ram #(
    .WIDTH (vsr_pkg::DATA_W),
    .DEPTH (NUM_VECTORS),
    .AW    (VAW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vsr_ctrl #(
    .NUM_VECTORS (NUM_VECTORS),
    .ADDR_BITS   (ADDR_BITS),
    .NUM_REGS    (NUM_REGS),
    .VAW         (VAW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .item            (item),
    .stack_direction (stack_direction),
    .busy            (busy),
    .result_valid    (result_valid),
    .result          (result),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

`ifndef ASSERT_OFF
  // A word that is not the last of its command must leave the block busy.
  a_more_words_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final word while sequencer idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_save_wakes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.mem_op == vsr_pkg::MEM_WRITE |-> result.wake)
    else $error("save word without wake");

  a_clear_on_return_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clear_exception |->
      result.last && result.mem_op == vsr_pkg::MEM_READ)
    else $error("exception cleared outside the final restore word");
`endif

endmodule

// ===== tb/vectored_interrupt_save_restore_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vectored_interrupt_save_restore_test
// Self-checking bench for the vectored interrupt save and restore block. A
// directed run covers field extremes, invalid ids, untaken fires and address
// wrap in both stack directions. Random commands follow, with idle gaps, over
// several direction settings. Every result word is compared with an
// independent prediction of the vector table, enable mask and stack sequencing.
// ----------------------------------------------------------------------------
module vectored_interrupt_save_restore_test;

  localparam int unsigned VEC_COUNT     = 9;
  localparam int unsigned REG_COUNT     = 32;
  localparam int unsigned PHASE_ITEMS   = 120;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 40;

  localparam logic [vsr_pkg::REG_SEL_W-1:0] FLAGS_SEL  = vsr_pkg::REG_SEL_W'(REG_COUNT);
  localparam logic [2:0]                    CMD_SPARE6 = 3'd6;
  localparam logic [2:0]                    CMD_SPARE7 = 3'd7;
  localparam logic [vsr_pkg::DATA_W-1:0]    ADDR_TOP   = '1;
  localparam logic [vsr_pkg::DATA_W-1:0]    ADDR_ODD   = 27'h7ffe00f;

  // Tracks the block's table, mask and direction, and holds the words still due.
  class vsr_word_predictor;
    logic [vsr_pkg::DATA_W-1:0] vectors [VEC_COUNT];
    logic [vsr_pkg::MASK_W-1:0] enabled;
    logic                       push_up;
    vsr_pkg::result_t           expected_words [$];
    int unsigned                mismatches;

    function new();
      foreach (vectors[i]) vectors[i] = '0;
      enabled    = '0;
      push_up    = 1'b0;
      mismatches = 0;
    endfunction

    function void set_direction(logic d);
      push_up = d;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // One save or restore: the registers and the flags register, one word each.
    function void queue_stack_burst(logic [1:0] op, logic [vsr_pkg::DATA_W-1:0] sp,
                                    logic down, logic [vsr_pkg::DATA_W-1:0] pc);
      vsr_pkg::result_t           w;
      logic [vsr_pkg::DATA_W-1:0] addr;
      int                         n;
      for (n = 0; n <= REG_COUNT; n++) begin
        w        = '0;
        w.mem_op = op;
        w.wake   = (op == vsr_pkg::MEM_WRITE);
        if (down) begin
          addr      = sp - vsr_pkg::DATA_W'(vsr_pkg::ADDR_STEP * (n + 1));
          w.reg_sel = (n == 0) ? FLAGS_SEL : vsr_pkg::REG_SEL_W'(REG_COUNT - n);
        end else begin
          addr      = sp + vsr_pkg::DATA_W'(vsr_pkg::ADDR_STEP * n);
          w.reg_sel = vsr_pkg::REG_SEL_W'(n);
        end
        w.mem_addr = addr;
        if (n == REG_COUNT) begin
          w.branch_taken = 1'b1;
          w.last         = 1'b1;
          if (op == vsr_pkg::MEM_WRITE) begin
            w.new_pc    = pc;
            w.new_stack = down ? addr : addr + vsr_pkg::DATA_W'(vsr_pkg::ADDR_STEP);
          end else begin
            w.clear_exception = 1'b1;
          end
        end
        expected_words.push_back(w);
      end
    endfunction

    function void note_command(vsr_pkg::item_t it);
      vsr_pkg::result_t w;
      logic             id_ok;
      id_ok = (it.irq_id < VEC_COUNT);
      if (it.cmd == vsr_pkg::CMD_RETURN) begin
        queue_stack_burst(vsr_pkg::MEM_READ, it.stack_pointer, push_up, '0);
        return;
      end
      if (it.cmd == vsr_pkg::CMD_FIRE && id_ok && vectors[it.irq_id] != '0 &&
          enabled[it.irq_id]) begin
        queue_stack_burst(vsr_pkg::MEM_WRITE, it.stack_pointer, !push_up,
                          vectors[it.irq_id]);
        return;
      end
      w      = '0;
      w.last = 1'b1;
      case (it.cmd)
        vsr_pkg::CMD_SET:     if (id_ok) vectors[it.irq_id] = it.vector_value;
        vsr_pkg::CMD_GET:     if (id_ok) w.read_vector = vectors[it.irq_id];
        vsr_pkg::CMD_ENABLE:  enabled = it.id_mask;
        vsr_pkg::CMD_DISABLE: enabled = ~it.id_mask;
        vsr_pkg::CMD_FIRE:    w.wake = id_ok;
        default:              ;
      endcase
      expected_words.push_back(w);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(vsr_pkg::result_t got);
      vsr_pkg::result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("read_vector", want.read_vector, got.read_vector);
      compare_field("mem_op", want.mem_op, got.mem_op);
      compare_field("mem_addr", want.mem_addr, got.mem_addr);
      compare_field("reg_sel", want.reg_sel, got.reg_sel);
      compare_field("wake", want.wake, got.wake);
      compare_field("branch_taken", want.branch_taken, got.branch_taken);
      compare_field("new_pc", want.new_pc, got.new_pc);
      compare_field("new_stack", want.new_stack, got.new_stack);
      compare_field("clear_exception", want.clear_exception, got.clear_exception);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             start        = 1'b0;
  logic             busy;
  vsr_pkg::item_t   cmd_item     = '0;
  logic             result_valid;
  vsr_pkg::result_t out_word;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic             cfg_data     = 1'b0;
  bit               quiet_phase  = 1'b0;

  vsr_word_predictor predictor;

  vectored_interrupt_save_restore #(
    .NUM_VECTORS(VEC_COUNT),
    .ADDR_BITS  (vsr_pkg::DATA_W),
    .NUM_REGS   (REG_COUNT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (cmd_item),
    .result_valid(result_valid),
    .result      (out_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Commands and result words are both taken at the clock edge, from the values
  // that stood just before it.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predictor.note_command(cmd_item);
      if (result_valid) predictor.check_word(out_word);
    end
  end

  function automatic vsr_pkg::item_t make_cmd(logic [2:0] cmd, logic [3:0] id,
                                              logic [vsr_pkg::DATA_W-1:0] vval,
                                              logic [vsr_pkg::MASK_W-1:0] ids,
                                              logic [vsr_pkg::DATA_W-1:0] sp);
    vsr_pkg::item_t it;
    it.cmd           = cmd;
    it.irq_id        = id;
    it.vector_value  = vval;
    it.id_mask       = ids;
    it.stack_pointer = sp;
    return it;
  endfunction

  function automatic vsr_pkg::item_t random_command();
    vsr_pkg::item_t it;
    logic [31:0]    r0;
    logic [31:0]    r1;
    logic [31:0]    r2;
    int             pick;
    r0   = $urandom;
    r1   = $urandom;
    r2   = $urandom;
    pick = $urandom_range(0, 99);
    it.irq_id       = r0[3:0];
    it.vector_value = ($urandom_range(0, 9) == 0) ? '0 : r1[vsr_pkg::DATA_W-1:0];
    it.id_mask      = r0[vsr_pkg::MASK_W+3:4];
    case ($urandom_range(0, 7))
      0:       it.stack_pointer = vsr_pkg::DATA_W'($urandom_range(0, 120));
      1:       it.stack_pointer = ADDR_TOP - vsr_pkg::DATA_W'($urandom_range(0, 120));
      default: it.stack_pointer = r2[vsr_pkg::DATA_W-1:0];
    endcase
    if (pick < 14) begin
      it.cmd = vsr_pkg::CMD_SET;
    end else if (pick < 24) begin
      it.cmd = vsr_pkg::CMD_GET;
    end else if (pick < 32) begin
      // Lean towards wide masks so that most fires are taken.
      it.cmd     = vsr_pkg::CMD_ENABLE;
      it.id_mask = it.id_mask | r2[vsr_pkg::MASK_W+13:14];
    end else if (pick < 37) begin
      it.cmd     = vsr_pkg::CMD_DISABLE;
      it.id_mask = it.id_mask & r2[vsr_pkg::MASK_W+13:14];
    end else if (pick < 72) begin
      it.cmd = vsr_pkg::CMD_FIRE;
      if ($urandom_range(0, 99) < 88) it.irq_id = 4'($urandom_range(0, VEC_COUNT - 1));
    end else if (pick < 95) begin
      it.cmd = vsr_pkg::CMD_RETURN;
    end else begin
      it.cmd = r0[31] ? CMD_SPARE7 : CMD_SPARE6;
    end
    return it;
  endfunction

  task automatic send_command(input vsr_pkg::item_t it);
    int gap;
    start    <= 1'b1;
    cmd_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!quiet_phase && $urandom_range(0, 99) < 21) begin
      gap = $urandom_range(1, 40);
      start    <= 1'b0;
      cmd_item <= random_command();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every outstanding word has come back, then writes the direction.
  task automatic write_direction(input logic d);
    start <= 1'b0;
    do @(posedge clk); while (predictor.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    predictor.set_direction(d);
  endtask

  initial begin
    int phase;
    int n;
    predictor = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_direction(1'b0);
    send_command(make_cmd(vsr_pkg::CMD_GET, 4'd0, '0, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd0, '0, '0, 27'd5));
    send_command(make_cmd(vsr_pkg::CMD_SET, 4'd0, ADDR_TOP, '1, ADDR_TOP));
    send_command(make_cmd(vsr_pkg::CMD_SET, 4'd8, 27'd1, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_SET, 4'd9, 27'h5555555, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_GET, 4'd9, '0, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_GET, 4'd8, '0, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_GET, 4'd15, ADDR_TOP, '1, '0));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd0, '0, '0, 27'd100));
    send_command(make_cmd(vsr_pkg::CMD_ENABLE, 4'd0, '0, 9'h1ff, '0));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd0, '0, '0, 27'd2));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd8, '0, '0, ADDR_TOP));
    send_command(make_cmd(vsr_pkg::CMD_RETURN, 4'd15, '0, '0, ADDR_TOP));
    send_command(make_cmd(vsr_pkg::CMD_RETURN, 4'd0, '0, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd15, '1, '1, 27'd64));
    send_command(make_cmd(vsr_pkg::CMD_DISABLE, 4'd0, '0, 9'h1fe, '0));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd8, '0, '0, 27'd300));
    send_command(make_cmd(CMD_SPARE6, 4'd3, '1, '1, '1));
    send_command(make_cmd(CMD_SPARE7, 4'd8, '1, '1, '1));

    write_direction(1'b1);
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd0, '0, '0, ADDR_TOP));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd0, '0, '0, ADDR_ODD));
    send_command(make_cmd(vsr_pkg::CMD_RETURN, 4'd0, '0, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_RETURN, 4'd0, '0, '0, ADDR_ODD));
    send_command(make_cmd(vsr_pkg::CMD_SET, 4'd0, '0, '0, '0));
    send_command(make_cmd(vsr_pkg::CMD_FIRE, 4'd0, '0, '0, 27'd9));

    // The third random phase runs back to back with no gaps at all.
    for (phase = 0; phase < 4; phase++) begin
      write_direction(phase[0]);
      quiet_phase = (phase == 2);
      for (n = 0; n < PHASE_ITEMS; n++) send_command(random_command());
    end

    start <= 1'b0;
    do @(posedge clk); while (predictor.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predictor.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vsr_pkg.sv
sv/vsr_ram.sv
sv/vsr_ctrl.sv
sv/vectored_interrupt_save_restore.sv
tb/vectored_interrupt_save_restore_test.sv
